### hw/rtl/ppm_pkg.sv
// shared types and constants of the pairwise precedence matrix
package ppm_pkg;

	// default sizes of the table
	localparam int MAX_GENES_DEF  = 64;
	localparam int COUNT_BITS_DEF = 16;

	// width of the divider in the fraction path
	localparam int DIV_W = 16;

	// gene count after reset
	localparam logic [6:0] NUM_GENES_RST = 7'd64;

	// completed rankings saturate here
	localparam logic [15:0] DONE_MAX = 16'hFFFF;

	// fraction of one in unsigned q1.16
	localparam logic [16:0] FRAC_ONE = 17'h10000;

	typedef enum logic [1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_GENE_RANGE  = 2'd1,
		STATUS_READ_RANGE  = 2'd2,
		STATUS_NO_RANKINGS = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PUSH,
		ST_RDWAIT,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		func_t      func;
		logic [5:0] gene;
		logic [5:0] row;
		logic [5:0] col;
	} in_item_t;

	typedef struct packed {
		logic [16:0] fraction;
		logic [15:0] pair_count;
		logic [15:0] rankings_done;
		status_t     status;
	} out_item_t;

	// request to the fraction divider
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

endpackage

### hw/rtl/pairwise_precedence_matrix.sv
// Pairwise precedence matrix: counts how often gene i precedes gene j over pushed rankings.
// A push walks every earlier gene of its ranking: each costs one read-modify-write of the
// count ram, issued one per cycle behind a three-stage pipe (ranking ram read, count ram
// read, write back) with forwarding of the previous write. A read in range goes through a
// count ram read and, when the fraction needs it, the 16-step divider; a rejected item or a
// no-op goes straight to its result. A clear, and reset, sweep the count ram one entry per
// cycle while no input is taken, and a clear answers once its sweep is done. The next input
// transfer comes in the cycle after a result is loaded at the earliest; num_genes writes
// are taken at any time. The output register lets the next input transfer while a result
// still waits.
module pairwise_precedence_matrix import ppm_pkg::*; #(
	parameter int MAX_GENES  = MAX_GENES_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [6:0] cfg_data,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int GW  = $clog2(MAX_GENES);
	localparam int PW  = $clog2(MAX_GENES + 1);
	localparam int LW  = (PW > 7) ? PW : 7;
	localparam int TW  = 2 * GW;
	localparam int PCW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	state_t state_q, state_d;

	logic [6:0]    num_genes_q;
	logic [LW-1:0] n_eff;
	logic [PW-1:0] position_q;
	logic [15:0]   done_q;
	logic [GW-1:0] k_q;
	logic [GW-1:0] p_q;
	logic [GW-1:0] gene_q;
	logic [TW-1:0] clr_addr_q;
	logic          clr_op_q;
	out_item_t     res_q;
	out_item_t     out_q;
	logic          out_valid_q;

	// push pipeline
	logic          rank_v_s1;
	logic          cnt_v_s2;
	logic [TW-1:0] cnt_addr_s2;

	// last write to the count ram
	logic                  fw_v_q;
	logic [TW-1:0]         fw_addr_q;
	logic [COUNT_BITS-1:0] fw_data_q;

	// ram ports
	logic                  rank_we;
	logic [GW-1:0]         rank_waddr;
	logic [GW-1:0]         rank_wdata;
	logic [GW-1:0]         rank_rdata;
	logic                  cnt_we;
	logic [TW-1:0]         cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic [TW-1:0]         cnt_raddr;
	logic [COUNT_BITS-1:0] cnt_rdata;
	logic [COUNT_BITS-1:0] cnt_cur;

	// decode
	logic          acc;
	logic          gene_ok;
	logic          rc_ok;
	logic [PW-1:0] p_clamp;
	logic [PW-1:0] p_next;
	logic          wrap;
	logic [15:0]   done_inc;
	logic          issue;
	logic          push_end;
	logic          clr_end;
	logic          need_div;
	logic          out_load;

	div_req_t         div_req;
	logic             div_busy;
	logic [DIV_W-1:0] div_quot;

	// effective gene count, clamped to between 2 and the table size
	always_comb begin
		if (LW'(num_genes_q) < LW'(2)) begin
			n_eff = LW'(2);
		end else if (LW'(num_genes_q) > LW'(MAX_GENES)) begin
			n_eff = LW'(MAX_GENES);
		end else begin
			n_eff = LW'(num_genes_q);
		end
	end

	// input decode and ranking bookkeeping
	always_comb begin
		acc      = in_valid && in_ready;
		gene_ok  = LW'(in_data.gene) < n_eff;
		rc_ok    = (LW'(in_data.row) < n_eff) && (LW'(in_data.col) < n_eff);
		p_clamp  = (position_q >= PW'(MAX_GENES)) ? PW'(MAX_GENES - 1) : position_q;
		p_next   = p_clamp + PW'(1);
		wrap     = LW'(p_next) >= n_eff;
		done_inc = (done_q == DONE_MAX) ? done_q : done_q + 16'd1;
		issue    = (state_q == ST_PUSH) && (k_q != p_q);
		push_end = (state_q == ST_PUSH) && !issue && !rank_v_s1 && !cnt_v_s2;
		clr_end  = clr_addr_q == {TW{1'b1}};
		out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	// count read data with forwarding of the previous cycle's write
	assign cnt_cur = (fw_v_q && (fw_addr_q == cnt_addr_s2)) ? fw_data_q : cnt_rdata;

	assign need_div = (done_q != 16'd0) && (PCW'(cnt_cur) < PCW'(done_q));

	// ranking ram ports
	always_comb begin
		rank_we    = acc && (in_data.func == FUNC_PUSH) && gene_ok;
		rank_waddr = GW'(p_clamp);
		rank_wdata = GW'(in_data.gene);
	end

	// count ram ports
	always_comb begin
		if (state_q == ST_PUSH) begin
			cnt_raddr = {rank_rdata, gene_q};
		end else begin
			cnt_raddr = {GW'(in_data.row), GW'(in_data.col)};
		end
		if (state_q == ST_CLEAR) begin
			cnt_we    = 1'b1;
			cnt_waddr = clr_addr_q;
			cnt_wdata = '0;
		end else begin
			cnt_we    = cnt_v_s2;
			cnt_waddr = cnt_addr_s2;
			cnt_wdata = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
		end
	end

	// divider request
	always_comb begin
		div_req.start    = (state_q == ST_RDWAIT) && need_div;
		div_req.dividend = DIV_W'(cnt_cur);
		div_req.divisor  = done_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_end) begin
					state_d = clr_op_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					case (in_data.func)
						FUNC_PUSH:  state_d = gene_ok ? ST_PUSH : ST_DONE;
						FUNC_READ:  state_d = rc_ok ? ST_RDWAIT : ST_DONE;
						FUNC_CLEAR: state_d = ST_CLEAR;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_PUSH: begin
				if (push_end) begin
					state_d = ST_DONE;
				end
			end
			ST_RDWAIT: begin
				state_d = need_div ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				if (!div_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			num_genes_q <= NUM_GENES_RST;
			position_q  <= '0;
			done_q      <= '0;
			clr_addr_q  <= '0;
			clr_op_q    <= 1'b0;
			k_q         <= '0;
			rank_v_s1   <= 1'b0;
			cnt_v_s2    <= 1'b0;
			fw_v_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rank_v_s1 <= issue;
			cnt_v_s2  <= (state_q == ST_PUSH) && rank_v_s1;
			fw_v_q    <= cnt_we;
			if (cfg_we) begin
				num_genes_q <= cfg_data;
			end
			// clearing sweep
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + TW'(1);
			end
			if (acc && (in_data.func == FUNC_CLEAR)) begin
				clr_addr_q <= '0;
				clr_op_q   <= 1'b1;
				position_q <= '0;
				done_q     <= '0;
			end
			// ranking position and completed count
			if (rank_we) begin
				position_q <= wrap ? '0 : p_next;
				if (wrap) begin
					done_q <= done_inc;
				end
			end
			// earlier-gene walk
			if (rank_we) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + GW'(1);
			end
			// output register
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cnt_addr_s2 <= cnt_raddr;
		fw_addr_q   <= cnt_waddr;
		fw_data_q   <= cnt_wdata;
		if (rank_we) begin
			p_q    <= GW'(p_clamp);
			gene_q <= GW'(in_data.gene);
		end
		// result assembly on transfer in
		if (acc) begin
			res_q.fraction      <= '0;
			res_q.pair_count    <= '0;
			res_q.rankings_done <= done_q;
			res_q.status        <= STATUS_OK;
			case (in_data.func)
				FUNC_PUSH: begin
					if (!gene_ok) begin
						res_q.status <= STATUS_GENE_RANGE;
					end else if (wrap) begin
						res_q.rankings_done <= done_inc;
					end
				end
				FUNC_READ: begin
					if (!rc_ok) begin
						res_q.status <= STATUS_READ_RANGE;
					end
				end
				FUNC_CLEAR: res_q.rankings_done <= '0;
				default:    res_q.status <= STATUS_OK;
			endcase
		end
		// count read back
		if (state_q == ST_RDWAIT) begin
			res_q.pair_count <= 16'(cnt_cur);
			if (done_q == 16'd0) begin
				res_q.status <= STATUS_NO_RANKINGS;
			end else if (!need_div) begin
				res_q.fraction <= FRAC_ONE;
			end
		end
		if ((state_q == ST_DIV) && !div_busy) begin
			res_q.fraction <= {1'b0, div_quot};
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	// genes of the ranking in progress
	ppm_ram #(
		.AW (GW),
		.DW (GW)
	) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (rank_waddr),
		.wdata (rank_wdata),
		.raddr (k_q),
		.rdata (rank_rdata)
	);

	// precedence counts
	ppm_ram #(
		.AW (TW),
		.DW (COUNT_BITS)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	// fraction divider
	ppm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// no table write outstanding once idle
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !cnt_we)
		else $error("count ram written while idle");

	// push pipe drained before the next transfer
	a_ready_drained: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!rank_v_s1 && !cnt_v_s2))
		else $error("push pipeline busy while ready");

	// a result only comes from the done state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done state");

	// fraction never above one
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.fraction <= FRAC_ONE))
		else $error("fraction above one");

endmodule

### hw/rtl/ppm_ram.sv
// simple dual-port synchronous ram with registered read data
module ppm_ram #(
	parameter int AW = 6,
	parameter int DW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, old data on a same-address write
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/ppm_div.sv
// restoring divider, one quotient bit per cycle, dividend below divisor
module ppm_div import ppm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output logic             busy,
	output logic [DIV_W-1:0] quotient
);

	localparam int SW = $clog2(DIV_W + 1);

	logic             busy_q;
	logic [SW-1:0]    step_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quot_q;
	logic [DIV_W-1:0] dvs_q;
	logic [DIV_W:0]   rem_sh;
	logic [DIV_W:0]   rem_diff;
	logic             take;

	// one trial subtraction
	always_comb begin
		rem_sh   = {rem_q, 1'b0};
		take     = rem_sh >= {1'b0, dvs_q};
		rem_diff = rem_sh - {1'b0, dvs_q};
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= SW'(DIV_W);
		end else if (busy_q) begin
			step_q <= step_q - SW'(1);
			if (step_q == SW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// partial remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.dividend;
			quot_q <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			rem_q  <= take ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			quot_q <= {quot_q[DIV_W-2:0], take};
		end
	end

	assign busy     = busy_q;
	assign quotient = quot_q;

endmodule
